### hdl/tril_pkg.sv
`default_nettype none

package tril_pkg;

    localparam int TimeWidth   = 64;
    localparam int OffsetWidth = 48;
    localparam int SizeWidth   = 32;

    localparam int InDataWidth  = 3 * TimeWidth + OffsetWidth + SizeWidth;
    localparam int OutDataWidth = OffsetWidth + SizeWidth;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic [TimeWidth-1:0]   start_time;
        logic [TimeWidth-1:0]   end_time;
        logic [OffsetWidth-1:0] offset;
        logic [SizeWidth-1:0]   size;
    } entry_t;

    typedef struct packed {
        logic                   valid;
        logic                   found;
        logic [TimeWidth-1:0]   lookup_time;
        logic [OffsetWidth-1:0] offset;
        logic [SizeWidth-1:0]   size;
    } token_t;

endpackage

`default_nettype wire

### hdl/tril_cell.sv
`default_nettype none

module tril_cell
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift,
    input  wire logic             entry_valid_in,
    input  wire tril_pkg::entry_t entry_in,
    output logic                  entry_valid_out,
    output tril_pkg::entry_t      entry_out,
    input  wire tril_pkg::token_t tok_in,
    output tril_pkg::token_t      tok_out
);

    logic             valid_reg;
    tril_pkg::entry_t entry_reg;
    logic             tok_valid_reg;
    tril_pkg::token_t tok_reg;
    tril_pkg::token_t tok_next;
    logic             hit;

    assign hit = tok_in.valid && !tok_in.found && valid_reg &&
                 (tok_in.lookup_time >= entry_reg.start_time) &&
                 (tok_in.lookup_time <= entry_reg.end_time);

    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found  = 1'b1;
            tok_next.offset = entry_reg.offset;
            tok_next.size   = entry_reg.size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            if (shift)
            begin
                valid_reg <= entry_valid_in;
            end
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= entry_in;
        end
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

    assign entry_valid_out = valid_reg;
    assign entry_out       = entry_reg;

endmodule

`default_nettype wire

### hdl/time_range_index_lookup.sv
`default_nettype none

// Channel | Direction | tdata (lowest bit up)                          | tuser
// s_*     | in        | range_start, range_end, data_offset,           | req_type
//         |           | block_size, lookup_time (272 bits)             |
// m_*     | out       | match_offset, match_size (80 bits)             | found
//
// Entries sit in a chain of DEPTH cells, newest in the first cell. An insert shifts every
// entry one cell down, dropping the oldest when the chain is full. A lookup walks the
// chain as a search transaction, one cell per cycle, so the input is closed from the
// lookup until its search transaction leaves the last cell.
// Reset clears every valid mark at once; no clearing pass is needed.
// A result waiting on m_tready does not hold back the next insert or lookup; a second
// result finished behind it waits in a holding register with the input closed.

module time_range_index_lookup
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // range_start, range_end, data_offset, block_size, lookup_time
    input  wire logic [tril_pkg::InDataWidth-1:0]  s_tdata,
    // req_type
    input  wire logic [0:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // match_offset, match_size
    output logic [tril_pkg::OutDataWidth-1:0]      m_tdata,
    // found
    output logic [0:0]                             m_tuser
);

    localparam int TW = tril_pkg::TimeWidth;
    localparam int OW = tril_pkg::OffsetWidth;
    localparam int SW = tril_pkg::SizeWidth;

    tril_pkg::entry_t entry_chain [DEPTH+1];
    logic             valid_chain [DEPTH+1];
    tril_pkg::token_t tok_chain   [DEPTH+1];

    logic             s_accept;
    logic             do_insert;
    logic             do_lookup;
    logic             out_free;
    logic             chain_busy_reg;
    logic             hold_valid_reg;
    tril_pkg::token_t hold_reg;
    logic             m_tvalid_reg;
    logic             found_reg;
    logic [OW-1:0]    offset_reg;
    logic [SW-1:0]    size_reg;

    assign s_tready  = !chain_busy_reg && !hold_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign do_insert = s_accept && (s_tuser[0] == tril_pkg::REQ_INSERT);
    assign do_lookup = s_accept && (s_tuser[0] == tril_pkg::REQ_LOOKUP);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign valid_chain[0]            = 1'b1;
    assign entry_chain[0].start_time = s_tdata[TW-1:0];
    assign entry_chain[0].end_time   = s_tdata[2*TW-1:TW];
    assign entry_chain[0].offset     = s_tdata[2*TW+OW-1:2*TW];
    assign entry_chain[0].size       = s_tdata[2*TW+OW+SW-1:2*TW+OW];
    assign tok_chain[0].valid        = do_lookup;
    assign tok_chain[0].found        = 1'b0;
    assign tok_chain[0].lookup_time  = s_tdata[3*TW+OW+SW-1:2*TW+OW+SW];
    assign tok_chain[0].offset       = '0;
    assign tok_chain[0].size         = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tril_cell u_cell
        (
            .clk             (clk),
            .rst_n           (rst_n),
            .shift           (do_insert),
            .entry_valid_in  (valid_chain[i]),
            .entry_in        (entry_chain[i]),
            .entry_valid_out (valid_chain[i+1]),
            .entry_out       (entry_chain[i+1]),
            .tok_in          (tok_chain[i]),
            .tok_out         (tok_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_busy_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (do_lookup)
            begin
                chain_busy_reg <= 1'b1;
            end
            else if (tok_chain[DEPTH].valid)
            begin
                chain_busy_reg <= 1'b0;
            end

            if (tok_chain[DEPTH].valid && !out_free)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (hold_valid_reg && out_free)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (out_free)
            begin
                m_tvalid_reg <= tok_chain[DEPTH].valid || hold_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_chain[DEPTH].valid && !out_free)
        begin
            hold_reg <= tok_chain[DEPTH];
        end
        if (out_free)
        begin
            if (hold_valid_reg)
            begin
                found_reg  <= hold_reg.found;
                offset_reg <= hold_reg.offset;
                size_reg   <= hold_reg.size;
            end
            else
            begin
                found_reg  <= tok_chain[DEPTH].found;
                offset_reg <= tok_chain[DEPTH].offset;
                size_reg   <= tok_chain[DEPTH].size;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {size_reg, offset_reg};
    assign m_tuser[0] = found_reg;

endmodule

`default_nettype wire

### hdl/tril_checker.sv
`default_nettype none

module tril_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [0:0]                        s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [tril_pkg::OutDataWidth-1:0] m_tdata,
    input wire logic [0:0]                        m_tuser
);

    logic s_accept;

    assign s_accept = s_tvalid && s_tready;

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // A lookup closes the input while it walks the chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (s_tuser[0] == tril_pkg::REQ_LOOKUP) |=> !s_tready)
    else $error("input open right after a lookup");

    // A miss carries zero offset and size.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("miss with nonzero payload");

    // An insert never produces a result transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (s_tuser[0] == tril_pkg::REQ_INSERT) && !m_tvalid |=> !m_tvalid)
    else $error("result appeared after an insert");

    // Before any lookup, the input is not closed once reset ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> s_tready)
    else $error("input closed after reset");

endmodule

bind time_range_index_lookup tril_checker u_tril_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/range_lookup_checker.sv
`timescale 1ns / 100ps

module range_lookup_checker
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    // range_start, range_end, data_offset, block_size, lookup_time
    input  wire logic [tril_pkg::InDataWidth-1:0]  s_tdata,
    // req_type
    input  wire logic [0:0]                        s_tuser,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // match_offset, match_size
    input  wire logic [tril_pkg::OutDataWidth-1:0] m_tdata,
    // found
    input  wire logic [0:0]                        m_tuser,
    output int                                     mismatch_count,
    output int                                     outstanding
);

    localparam int   TimeWidth    = tril_pkg::TimeWidth;
    localparam int   OffsetWidth  = tril_pkg::OffsetWidth;
    localparam int   SizeWidth    = tril_pkg::SizeWidth;
    localparam int   OutDataWidth = tril_pkg::OutDataWidth;
    localparam logic REQ_INSERT   = tril_pkg::REQ_INSERT;

    typedef tril_pkg::entry_t entry_t;

    localparam int StartLo  = 0;
    localparam int StopLo   = TimeWidth;
    localparam int OffsetLo = 2 * TimeWidth;
    localparam int SizeLo   = OffsetLo + OffsetWidth;
    localparam int LookupLo = SizeLo + SizeWidth;

    typedef struct packed {
        logic                   found;
        logic [OffsetWidth-1:0] offset;
        logic [SizeWidth-1:0]   size;
    } match_t;

    entry_t table_entry [DEPTH];
    logic   entry_live [DEPTH];
    int     next_slot;
    int     failures;
    match_t pending_matches [$];

    function automatic match_t newest_match(logic [TimeWidth-1:0] t);
        match_t r;
        int idx;
        r = '0;
        for (int k = 1; k <= DEPTH; k++)
        begin
            idx = (next_slot + DEPTH - k) % DEPTH;
            if (entry_live[idx] && t >= table_entry[idx].start_time
                && t <= table_entry[idx].end_time)
            begin
                r.found  = 1'b1;
                r.offset = table_entry[idx].offset;
                r.size   = table_entry[idx].size;
                return r;
            end
        end
        return r;
    endfunction

    task automatic report_miss(string what, match_t want, match_t seen);
        failures++;
        if (failures <= 10)
        begin
            $display("%0t: %s: found %0b/%0b offset %h/%h size %h/%h (expected/actual)",
                     $time, what, want.found, seen.found, want.offset, seen.offset,
                     want.size, seen.size);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        match_t seen;
        match_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_live[i] = 1'b0;
            end
            next_slot = 0;
            failures = 0;
            pending_matches.delete();
            mismatch_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == REQ_INSERT)
                begin
                    table_entry[next_slot].start_time = s_tdata[StartLo +: TimeWidth];
                    table_entry[next_slot].end_time   = s_tdata[StopLo +: TimeWidth];
                    table_entry[next_slot].offset     = s_tdata[OffsetLo +: OffsetWidth];
                    table_entry[next_slot].size       = s_tdata[SizeLo +: SizeWidth];
                    entry_live[next_slot] = 1'b1;
                    next_slot = (next_slot + 1) % DEPTH;
                end
                else
                begin
                    pending_matches.push_back(newest_match(s_tdata[LookupLo +: TimeWidth]));
                end
            end
            if (m_tvalid && m_tready)
            begin
                seen.found  = m_tuser[0];
                seen.offset = m_tdata[OffsetWidth-1:0];
                seen.size   = m_tdata[OutDataWidth-1:OffsetWidth];
                if (pending_matches.size() == 0)
                begin
                    report_miss("result with no lookup pending", '0, seen);
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (seen != want)
                    begin
                        report_miss("lookup result mismatch", want, seen);
                    end
                end
            end
            mismatch_count <= failures;
            outstanding <= pending_matches.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int   TimeWidth    = tril_pkg::TimeWidth;
    localparam int   OffsetWidth  = tril_pkg::OffsetWidth;
    localparam int   SizeWidth    = tril_pkg::SizeWidth;
    localparam int   InDataWidth  = tril_pkg::InDataWidth;
    localparam int   OutDataWidth = tril_pkg::OutDataWidth;
    localparam logic REQ_INSERT   = tril_pkg::REQ_INSERT;
    localparam logic REQ_LOOKUP   = tril_pkg::REQ_LOOKUP;

    localparam int DEPTH          = 16;
    localparam int RANDOM_ITEMS   = 1530;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HISTORY        = 32;

    localparam logic [TimeWidth-1:0]   TIME_MAX   = '1;
    localparam logic [OffsetWidth-1:0] OFFSET_MAX = '1;
    localparam logic [SizeWidth-1:0]   SIZE_MAX   = '1;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [InDataWidth-1:0]  s_tdata = '0;
    logic [0:0]              s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OutDataWidth-1:0] m_tdata;
    logic [0:0]              m_tuser;

    int mismatch_count;
    int outstanding;
    bit s_idle_on = 1'b1;
    bit m_idle_on = 1'b1;
    int ready_hold = 0;
    int quiet_cycles = 0;

    logic [TimeWidth-1:0] hist_start [HISTORY];
    logic [TimeWidth-1:0] hist_stop [HISTORY];
    int                   hist_count = 0;

    time_range_index_lookup #(.DEPTH(DEPTH)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    range_lookup_checker #(.DEPTH(DEPTH)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_idle_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 48);
    endfunction

    function automatic logic [TimeWidth-1:0] pick_time();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return TimeWidth'($urandom_range(0, 4000));
            5, 6:          return rand64();
            7:             return TIME_MAX - TimeWidth'($urandom_range(0, 4000));
            8:             return $urandom_range(0, 1) ? TIME_MAX : '0;
            default:       return rand64() >> $urandom_range(0, 63);
        endcase
    endfunction

    task automatic push_request(logic kind, logic [InDataWidth-1:0] data);
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (s_idle_on && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat (pick_idle_len()) @(posedge clk);
        end
    endtask

    task automatic send_insert(logic [TimeWidth-1:0] t_start, logic [TimeWidth-1:0] t_stop,
                               logic [OffsetWidth-1:0] offset, logic [SizeWidth-1:0] size);
        hist_start[hist_count % HISTORY] = t_start;
        hist_stop[hist_count % HISTORY]  = t_stop;
        hist_count++;
        push_request(REQ_INSERT, {rand64(), size, offset, t_stop, t_start});
    endtask

    task automatic send_lookup(logic [TimeWidth-1:0] t);
        push_request(REQ_LOOKUP, {t, SizeWidth'(rand64()), OffsetWidth'(rand64()),
                                  rand64(), rand64()});
    endtask

    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (m_idle_on && $urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            ready_hold <= pick_idle_len() - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        logic [TimeWidth-1:0] lo;
        logic [TimeWidth-1:0] hi;
        logic [TimeWidth-1:0] t;
        logic [TimeWidth-1:0] t_stop;
        int back;
        int k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lookups on the empty table, then full-span, narrow and empty ranges.
        send_lookup('0);
        send_lookup(TIME_MAX);
        send_insert('0, TIME_MAX, OFFSET_MAX, SIZE_MAX);
        send_lookup('0);
        send_lookup(TIME_MAX);
        send_insert(100, 200, 1, 2);
        send_lookup(100);
        send_lookup(200);
        send_lookup(99);
        send_lookup(201);
        send_insert(500, 400, 3, 4);
        send_lookup(450);
        send_lookup(400);
        send_insert(TIME_MAX, TIME_MAX, '0, '0);
        send_lookup(TIME_MAX);
        send_lookup(TIME_MAX - 1);
        send_insert(5, 5, 5, 5);
        send_lookup(4);
        send_lookup(5);
        send_lookup(6);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                s_idle_on = $urandom_range(0, 3) != 0;
                m_idle_on = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 9) < 4)
            begin
                t = pick_time();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: t_stop = t + TimeWidth'($urandom_range(0, 400));
                    7:                   t_stop = t - TimeWidth'($urandom_range(1, 50));
                    default:             t_stop = pick_time();
                endcase
                send_insert(t, t_stop, OffsetWidth'(rand64()), $urandom);
            end
            else
            begin
                if (hist_count > 0 && $urandom_range(0, 9) < 7)
                begin
                    back = $urandom_range(0, ((hist_count < 24) ? hist_count : 24) - 1);
                    k = (hist_count - 1 - back) % HISTORY;
                    lo = hist_start[k];
                    hi = hist_stop[k];
                    case ($urandom_range(0, 4))
                        0: t = lo;
                        1: t = hi;
                        2: t = lo - 1;
                        3: t = hi + 1;
                        default:
                        begin
                            if (hi >= lo && (hi - lo) != TIME_MAX)
                            begin
                                t = lo + rand64() % (hi - lo + 1);
                            end
                            else
                            begin
                                t = rand64();
                            end
                        end
                    endcase
                end
                else
                begin
                    t = pick_time();
                end
                send_lookup(t);
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4 * DEPTH) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### time_range_index_lookup.f
hdl/tril_pkg.sv
hdl/tril_cell.sv
hdl/time_range_index_lookup.sv
hdl/tril_checker.sv
tb/range_lookup_checker.sv
tb/tb.sv
